// ----- src/periodic_task_dispatch_table_assert.svh -----
// Assertion macros used by the task dispatch table back end.
`ifndef PERIODIC_TASK_DISPATCH_TABLE_ASSERT_SVH
`define PERIODIC_TASK_DISPATCH_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define PTDT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptdt assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PTDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptdt assertion failed");
`else
`define PTDT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PTDT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/ptdt_pkg.sv -----
// Shared constants, codes and types of the periodic task dispatch table.
`timescale 1ns / 1ps
package ptdt_pkg;

  // Table size and the most run results one dispatch request may give.
  localparam int NUM_TASKS   = 8;
  localparam int MAX_RESULTS = 8;

  // Field widths of the request and result channels.
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 6;
  localparam int HANDLE_W = 8;
  localparam int TIME_W   = 16;
  localparam int PEND_W   = 8;
  localparam int STATUS_W = 3;

  // Derived widths.
  localparam int IDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int RUN_W  = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_TASKS - 1);
  localparam logic [PEND_W-1:0] PEND_MAX = '1;

  // Command codes of a request.
  typedef enum logic [CMD_W-1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2,
    OP_DISP = 2'd3
  } op_t;

  // Status codes of a result.
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_DELETED = 3'd2,
    ST_DELERR  = 3'd3,
    ST_TICK    = 3'd4,
    ST_RUN     = 3'd5,
    ST_NONE    = 3'd6
  } status_t;

  // A classified request as it waits in the queue.
  typedef struct packed {
    op_t                 op;
    logic                slot_ok;
    logic [SLOT_W-1:0]   slot;
    logic [IDX_W-1:0]    addr;
    logic [HANDLE_W-1:0] task_handle;
    logic [TIME_W-1:0]   first_delay;
    logic [TIME_W-1:0]   run_period;
  } cmd_t;

  // One slot of the task table memory.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   countdown;
    logic [TIME_W-1:0]   period;
    logic [PEND_W-1:0]   pending;
  } entry_t;

endpackage

// ----- src/ptdt_front.sv -----
// Front end: takes requests and classifies them for the command queue.
`timescale 1ns / 1ps
module ptdt_front import ptdt_pkg::*; (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [HANDLE_W-1:0] in_task_handle,
  input  logic [TIME_W-1:0]   in_first_delay,
  input  logic [TIME_W-1:0]   in_run_period,
  input  logic                q_full,
  output logic                q_push,
  output cmd_t                q_data
);

  logic slot_ok;
  op_t  op;

  // A request is taken whenever the queue has room.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Decode the command and check the slot index against the table size.
  assign op      = op_t'(in_cmd);
  assign slot_ok = ({1'b0, in_slot} < (SLOT_W + 1)'(NUM_TASKS));

  // Delete of an in-range slot starts at that slot; every other request starts at slot zero.
  always_comb begin
    q_data             = '0;
    q_data.op          = op;
    q_data.slot_ok     = slot_ok;
    q_data.slot        = in_slot;
    q_data.task_handle = in_task_handle;
    q_data.first_delay = in_first_delay;
    q_data.run_period  = in_run_period;
    if (op == OP_DEL && slot_ok) begin
      q_data.addr = in_slot[IDX_W-1:0];
    end else begin
      q_data.addr = '0;
    end
  end

endmodule

// ----- src/ptdt_queue.sv -----
// Short command queue between the front end and the table sequencer.
`timescale 1ns / 1ps
module ptdt_queue import ptdt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t              fifo_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full     = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = fifo_r[rd_ptr_r];

  // Pointer and fill count updates with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset; the fill count guards it.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/ptdt_back.sv -----
// Back end: slot table and the sequencer that carries out each request.
`timescale 1ns / 1ps
`include "periodic_task_dispatch_table_assert.svh"
module ptdt_back import ptdt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                q_pop,
  input  cmd_t                q_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_result_slot,
  output logic [HANDLE_W-1:0] out_result_handle,
  output logic                out_last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [IDX_W-1:0]    proc_idx_r, proc_idx_nxt;
  logic [IDX_W-1:0]    rd_addr;
  logic [NUM_TASKS-1:0] valid_r, valid_nxt;
  logic                hold_vld_r, hold_vld_nxt;
  logic [IDX_W-1:0]    hold_idx_r, hold_idx_nxt;
  logic [HANDLE_W-1:0] hold_handle_r, hold_handle_nxt;
  logic [RUN_W-1:0]    run_cnt_r, run_cnt_nxt;

  entry_t              slot_mem_r [NUM_TASKS];
  entry_t              rdata_r;
  logic                mem_we;
  entry_t              mem_wdata;

  logic                out_vld_r;
  status_t             out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic                out_last_r;

  logic                emit_vld;
  status_t             emit_status;
  logic [SLOT_W-1:0]   emit_slot;
  logic [HANDLE_W-1:0] emit_handle;
  logic                emit_last;
  logic                out_free;
  logic                out_load;
  logic                stall;

  logic                cur_valid;
  logic                slot_ready;
  logic                at_last;

  assign cur_valid  = valid_r[proc_idx_r];
  assign slot_ready = cur_valid && (rdata_r.pending != '0);
  assign at_last    = (proc_idx_r == LAST_IDX);

  // Result selection for the current cycle of the sequencer.
  always_comb begin
    emit_vld    = 1'b0;
    emit_status = ST_TICK;
    emit_slot   = '0;
    emit_handle = '0;
    emit_last   = 1'b1;
    case (state_r)
      S_SCAN: begin
        case (cmd_r.op)
          OP_ADD: begin
            if (!cur_valid) begin
              emit_vld    = 1'b1;
              emit_status = ST_ADDED;
              emit_slot   = SLOT_W'(proc_idx_r);
              emit_handle = cmd_r.task_handle;
            end else if (at_last) begin
              emit_vld    = 1'b1;
              emit_status = ST_FULL;
            end
          end
          OP_DEL: begin
            emit_vld  = 1'b1;
            emit_slot = cmd_r.slot;
            if (cmd_r.slot_ok && cur_valid) begin
              emit_status = ST_DELETED;
              emit_handle = rdata_r.handle;
            end else begin
              emit_status = ST_DELERR;
            end
          end
          OP_TICK: begin
            if (at_last) begin
              emit_vld    = 1'b1;
              emit_status = ST_TICK;
            end
          end
          OP_DISP: begin
            // A held run goes out once a later one shows it was not the last.
            if (slot_ready && hold_vld_r) begin
              emit_vld    = 1'b1;
              emit_status = ST_RUN;
              emit_slot   = SLOT_W'(hold_idx_r);
              emit_handle = hold_handle_r;
              emit_last   = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      S_FLUSH: begin
        emit_vld = 1'b1;
        if (hold_vld_r) begin
          emit_status = ST_RUN;
          emit_slot   = SLOT_W'(hold_idx_r);
          emit_handle = hold_handle_r;
        end else begin
          emit_status = ST_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  // The sequencer holds still while a result cannot enter the output register.
  assign out_free = !out_vld_r || !out_stall;
  assign out_load = emit_vld && out_free;
  assign stall    = emit_vld && !out_free;

  // Next-state logic: one slot is visited per cycle during a scan unless a stall holds the scan.
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    proc_idx_nxt    = proc_idx_r;
    valid_nxt       = valid_r;
    hold_vld_nxt    = hold_vld_r;
    hold_idx_nxt    = hold_idx_r;
    hold_handle_nxt = hold_handle_r;
    run_cnt_nxt     = run_cnt_r;
    q_pop           = 1'b0;
    rd_addr         = proc_idx_r;
    mem_we          = 1'b0;
    mem_wdata       = rdata_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          cmd_nxt      = q_data;
          run_cnt_nxt  = '0;
          hold_vld_nxt = 1'b0;
          state_nxt    = S_LOAD;
        end
      end
      S_LOAD: begin
        // Fetch the first slot of the request.
        rd_addr      = cmd_r.addr;
        proc_idx_nxt = cmd_r.addr;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        if (!stall) begin
          case (cmd_r.op)
            OP_ADD: begin
              if (!cur_valid) begin
                mem_we                = 1'b1;
                mem_wdata.handle      = cmd_r.task_handle;
                mem_wdata.countdown   = cmd_r.first_delay;
                mem_wdata.period      = cmd_r.run_period;
                mem_wdata.pending     = '0;
                valid_nxt[proc_idx_r] = 1'b1;
                state_nxt             = S_IDLE;
              end else if (at_last) begin
                state_nxt = S_IDLE;
              end else begin
                proc_idx_nxt = proc_idx_r + 1'b1;
              end
            end
            OP_DEL: begin
              if (cmd_r.slot_ok && cur_valid) begin
                valid_nxt[proc_idx_r] = 1'b0;
              end
              state_nxt = S_IDLE;
            end
            OP_TICK: begin
              if (cur_valid) begin
                mem_we = 1'b1;
                if (rdata_r.countdown == '0) begin
                  if (rdata_r.pending != PEND_MAX) begin
                    mem_wdata.pending = rdata_r.pending + 1'b1;
                  end
                  if (rdata_r.period != '0) begin
                    mem_wdata.countdown = rdata_r.period;
                  end
                end else begin
                  mem_wdata.countdown = rdata_r.countdown - 1'b1;
                end
              end
              if (at_last) begin
                state_nxt = S_IDLE;
              end else begin
                proc_idx_nxt = proc_idx_r + 1'b1;
              end
            end
            OP_DISP: begin
              if (slot_ready) begin
                hold_vld_nxt      = 1'b1;
                hold_idx_nxt      = proc_idx_r;
                hold_handle_nxt   = rdata_r.handle;
                run_cnt_nxt       = run_cnt_r + 1'b1;
                mem_we            = 1'b1;
                mem_wdata.pending = rdata_r.pending - 1'b1;
                // A one-shot task leaves the table once it has run.
                if (rdata_r.period == '0) begin
                  valid_nxt[proc_idx_r] = 1'b0;
                end
              end
              if (at_last || (slot_ready && run_cnt_r == RUN_W'(MAX_RESULTS - 1))) begin
                state_nxt = S_FLUSH;
              end else begin
                proc_idx_nxt = proc_idx_r + 1'b1;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
        rd_addr = proc_idx_nxt;
      end
      S_FLUSH: begin
        if (!stall) begin
          hold_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, control and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      hold_vld_r <= 1'b0;
      run_cnt_r  <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      hold_vld_r <= hold_vld_nxt;
      run_cnt_r  <= run_cnt_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
    cmd_r         <= cmd_nxt;
    proc_idx_r    <= proc_idx_nxt;
    hold_idx_r    <= hold_idx_nxt;
    hold_handle_r <= hold_handle_nxt;
    if (out_load) begin
      out_status_r <= emit_status;
      out_slot_r   <= emit_slot;
      out_handle_r <= emit_handle;
      out_last_r   <= emit_last;
    end
  end

  // Slot table memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem_r[proc_idx_r] <= mem_wdata;
    end
    rdata_r <= slot_mem_r[rd_addr];
  end

  assign out_valid         = out_vld_r;
  assign out_status        = out_status_r;
  assign out_result_slot   = out_slot_r;
  assign out_result_handle = out_handle_r;
  assign out_last          = out_last_r;

  // The final run of a dispatch empties the hold register.
  `PTDT_ASSERT_NEXT(a_flush_clears_hold, clk, rst_n, (state_r == S_FLUSH) && !stall, !hold_vld_r)
  // A held run implies a counted run within the result limit.
  `PTDT_ASSERT_IMPL(a_run_cap, clk, rst_n, hold_vld_r, (run_cnt_r != '0) && (run_cnt_r <= RUN_W'(MAX_RESULTS)))
  // Runs are held only while a dispatch request is in progress.
  `PTDT_ASSERT_IMPL(a_hold_in_dispatch, clk, rst_n, hold_vld_r, (cmd_r.op == OP_DISP) && ((state_r == S_SCAN) || (state_r == S_FLUSH)))
  // A blocked scan neither moves on nor changes the table.
  `PTDT_ASSERT_NEXT(a_stall_freezes_scan, clk, rst_n, (state_r == S_SCAN) && stall, (state_r == S_SCAN) && $stable(proc_idx_r) && $stable(valid_r))

endmodule

// ----- src/periodic_task_dispatch_table.sv -----
// Top level of the periodic task dispatch table.
//
//   Channel   Direction  Handshake             Payload
//   in_       request    in_valid / in_stall   cmd, slot, task_handle, first_delay,
//                                              run_period
//   out_      result     out_valid / out_stall status, result_slot, result_handle, last
//
// A request waits in a two-entry command queue, so the input side keeps taking
// requests while the sequencer works. After a load step the sequencer visits one
// slot per cycle: delete only its own slot, add up to the first free slot, tick
// every slot, dispatch every slot and then a flush step (less when the result
// limit ends the scan early). Reset is synchronous and clears the valid bits,
// the queue and the output register; slot memory contents need no clearing.
// out_stall freezes the scan on the slot that wants to give a result.
`timescale 1ns / 1ps
module periodic_task_dispatch_table import ptdt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [HANDLE_W-1:0] in_task_handle,
  input  logic [TIME_W-1:0]   in_first_delay,
  input  logic [TIME_W-1:0]   in_run_period,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_result_slot,
  output logic [HANDLE_W-1:0] out_result_handle,
  output logic                out_last
);

  logic q_full;
  logic q_push;
  cmd_t q_push_data;
  logic q_pop;
  cmd_t q_pop_data;
  logic q_empty;

  // Request intake and classification.
  ptdt_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_slot        (in_slot),
    .in_task_handle (in_task_handle),
    .in_first_delay (in_first_delay),
    .in_run_period  (in_run_period),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_push_data)
  );

  // Command queue.
  ptdt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // Slot table and sequencer.
  ptdt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .q_data            (q_pop_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_result_slot   (out_result_slot),
    .out_result_handle (out_result_handle),
    .out_last          (out_last)
  );

endmodule
